// ----- design/nrzifr_pkg.sv -----
// nrzifr_pkg: shared constants and types for the nrzi bit recovery flag framer
// no dependencies; used by the frame interface and every design module

package nrzifr_pkg;

    localparam int SPB_W = 6;
    localparam logic [SPB_W-1:0] SPB_RESET = 6'd7;

    localparam int BYTE_W = 8;
    localparam int STAGE_W = 3;
    localparam int BIT_CNT_W = 3;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] CONTROL_BYTE = 8'h03;
    localparam logic [BYTE_W-1:0] PID_BYTE = 8'hF0;

    localparam logic [STAGE_W-1:0] STAGE_HUNT = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_FLAG = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_ADDR = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_CTRL = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_PID = 3'd4;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic valid;
        logic data;
    } bit_req_t;

endpackage

// ----- design/nrzifr_if.sv -----
// nrzifr_if: valid/ready channel interfaces for line samples and frame bytes
// depends on nrzifr_pkg

interface nrzifr_sample_if;
    logic valid;
    logic ready;
    logic line_sample;

    modport source (output valid, output line_sample, input ready);
    modport sink (input valid, input line_sample, output ready);
endinterface

interface nrzifr_frame_if;
    logic valid;
    logic ready;
    logic [nrzifr_pkg::BYTE_W-1:0] frame_byte;
    logic [nrzifr_pkg::STAGE_W-1:0] frame_stage;

    modport source (output valid, output frame_byte, output frame_stage, input ready);
    modport sink (input valid, input frame_byte, input frame_stage, output ready);
endinterface

// ----- design/nrzifr_front.sv -----
// nrzifr_front: edge detect and phase counter, turns line samples into nrzi bits
// depends on nrzifr_pkg

module nrzifr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_take,
    input  logic                          line_sample,
    input  logic [nrzifr_pkg::SPB_W-1:0]  bit_period,
    output nrzifr_pkg::bit_req_t          bit_out
);

    logic                         prev_level_reg, prev_level_next;
    logic                         first_seen_reg, first_seen_next;
    logic [nrzifr_pkg::SPB_W-1:0] phase_reg, phase_next;
    logic                         half_skip_reg, half_skip_next;
    logic [nrzifr_pkg::SPB_W-1:0] phase_base;
    logic                         half_skip_base;
    logic [nrzifr_pkg::SPB_W:0]   phase_inc;
    logic                         edge_bit;
    logic                         timeout;

    always_comb
    begin
        prev_level_next = prev_level_reg;
        first_seen_next = first_seen_reg;
        phase_base = phase_reg;
        half_skip_base = half_skip_reg;
        edge_bit = 1'b0;
        if (!first_seen_reg)
        begin
            first_seen_next = 1'b1;
            prev_level_next = line_sample;
        end
        else if (line_sample != prev_level_reg)
        begin
            prev_level_next = line_sample;
            phase_base = bit_period >> 1;
            half_skip_base = 1'b0;
            edge_bit = 1'b1;
        end

        phase_inc = {1'b0, phase_base} + {{nrzifr_pkg::SPB_W{1'b0}}, 1'b1};
        timeout = (bit_period != '0) && (phase_inc >= {1'b0, bit_period});

        half_skip_next = half_skip_base;
        bit_out.valid = edge_bit;
        bit_out.data = 1'b0;
        if (timeout)
        begin
            phase_next = '0;
            if (!half_skip_base)
            begin
                half_skip_next = 1'b1;
            end
            else
            begin
                bit_out.valid = 1'b1;
                bit_out.data = 1'b1;
            end
        end
        else
        begin
            phase_next = phase_inc[nrzifr_pkg::SPB_W-1:0];
        end

        bit_out.valid = bit_out.valid & sample_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            first_seen_reg <= 1'b0;
            phase_reg <= '0;
            half_skip_reg <= 1'b0;
        end
        else if (sample_take)
        begin
            prev_level_reg <= prev_level_next;
            first_seen_reg <= first_seen_next;
            phase_reg <= phase_next;
            half_skip_reg <= half_skip_next;
        end
    end

endmodule

// ----- design/nrzifr_fifo.sv -----
// nrzifr_fifo: short bit queue between bit recovery and the framer
// depends on nrzifr_pkg

module nrzifr_fifo #(
    parameter int DEPTH = nrzifr_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nrzifr_pkg::bit_req_t push,
    output logic                 full,
    output nrzifr_pkg::bit_req_t head,
    input  logic                 pop
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [DEPTH-1:0] slot_reg;
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == DEPTH_CNT);
    assign head.valid = (count_reg != '0);
    assign head.data = slot_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/nrzifr_back.sv -----
// nrzifr_back: flag hunt, byte assembly and frame stage tracking with output register
// depends on nrzifr_pkg and nrzifr_if

module nrzifr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nrzifr_pkg::bit_req_t head,
    output logic                 pop,
    nrzifr_frame_if.source       frame
);

    logic [nrzifr_pkg::BYTE_W-1:0]    window_reg, window_next;
    logic [nrzifr_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [nrzifr_pkg::STAGE_W-1:0]   stage_reg, stage_next;
    logic                             out_valid_reg;
    logic [nrzifr_pkg::BYTE_W-1:0]    out_byte_reg;
    logic [nrzifr_pkg::STAGE_W-1:0]   out_stage_reg;
    logic [nrzifr_pkg::BYTE_W-1:0]    shifted;
    logic [nrzifr_pkg::BIT_CNT_W-1:0] cnt_inc;
    logic                             emit;
    logic [nrzifr_pkg::BYTE_W-1:0]    emit_byte;

    assign pop = head.valid && (!out_valid_reg || frame.ready);
    assign frame.valid = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_stage = out_stage_reg;

    always_comb
    begin
        shifted = {head.data, window_reg[nrzifr_pkg::BYTE_W-1:1]};
        cnt_inc = bit_cnt_reg + 1'b1;
        window_next = shifted;
        bit_cnt_next = bit_cnt_reg;
        stage_next = stage_reg;
        emit = 1'b0;
        emit_byte = shifted;
        if (stage_reg == nrzifr_pkg::STAGE_HUNT)
        begin
            if (shifted == nrzifr_pkg::FLAG_BYTE)
            begin
                stage_next = nrzifr_pkg::STAGE_FLAG;
                emit = 1'b1;
                window_next = '0;
                bit_cnt_next = '0;
            end
        end
        else
        begin
            bit_cnt_next = cnt_inc;
            if (cnt_inc == '0)
            begin
                emit = 1'b1;
                window_next = '0;
                case (stage_reg)
                    nrzifr_pkg::STAGE_FLAG:
                    begin
                        if (shifted != nrzifr_pkg::FLAG_BYTE)
                        begin
                            stage_next = nrzifr_pkg::STAGE_ADDR;
                        end
                    end
                    nrzifr_pkg::STAGE_ADDR:
                    begin
                        if (shifted == nrzifr_pkg::CONTROL_BYTE)
                        begin
                            stage_next = nrzifr_pkg::STAGE_CTRL;
                        end
                    end
                    nrzifr_pkg::STAGE_CTRL:
                    begin
                        if (shifted == nrzifr_pkg::PID_BYTE)
                        begin
                            stage_next = nrzifr_pkg::STAGE_PID;
                        end
                    end
                    default:
                    begin
                        stage_next = stage_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            bit_cnt_reg <= '0;
            stage_reg <= nrzifr_pkg::STAGE_HUNT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                window_reg <= window_next;
                bit_cnt_reg <= bit_cnt_next;
                stage_reg <= stage_next;
            end
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_byte_reg <= emit_byte;
            out_stage_reg <= stage_next;
        end
    end

endmodule

// ----- design/nrzi_bit_recovery_flag_framer.sv -----
// channel   dir  payload                        notes
// sample    in   line_sample[0:0]               one sliced level per request
// frame     out  frame_byte[7:0], frame_stage   zero or one request per sample
// cfg       in   cfg_wr_en, cfg_wr_data[5:0]    samples per bit, write only
//
// one sample per cycle sustained while the queue is not full; a sample's bit enters the queue
// at the edge that accepts it, and a completed byte is presented on frame from the output register
// queued bits and frame stalls delay that byte; sample ready drops only when the queue fills
// rst_n clears all control state asynchronously, samples per bit resets to 7
// depends on nrzifr_pkg, nrzifr_if, nrzifr_front, nrzifr_fifo, nrzifr_back

module nrzi_bit_recovery_flag_framer #(
    parameter int QUEUE_DEPTH = nrzifr_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [nrzifr_pkg::SPB_W-1:0] cfg_wr_data,
    nrzifr_sample_if.sink                sample,
    nrzifr_frame_if.source               frame
);

    logic [nrzifr_pkg::SPB_W-1:0] spb_reg;
    logic                         queue_full;
    logic                         sample_take;
    logic                         pop;
    nrzifr_pkg::bit_req_t         bit_push;
    nrzifr_pkg::bit_req_t         bit_head;

    assign sample.ready = !queue_full;
    assign sample_take = sample.valid && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg <= nrzifr_pkg::SPB_RESET;
        end
        else if (cfg_wr_en)
        begin
            spb_reg <= cfg_wr_data;
        end
    end

    nrzifr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_take (sample_take),
        .line_sample (sample.line_sample),
        .bit_period  (spb_reg),
        .bit_out     (bit_push)
    );

    nrzifr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bit_push),
        .full  (queue_full),
        .head  (bit_head),
        .pop   (pop)
    );

    nrzifr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (bit_head),
        .pop   (pop),
        .frame (frame)
    );

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for nrzi_bit_recovery_flag_framer, predicts every frame byte
// drives nrzi-coded hdlc frames at several bit periods with random stalls on both sides
// depends on nrzifr_pkg, nrzifr_if and the design sources

`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD = 200;
    localparam int MAX_REPORTS = 100;
    localparam logic [23:0] DIRECTED_LEVELS = 24'b0101_1111_1100_0000_0010_0011;

    typedef struct packed {
        logic [nrzifr_pkg::BYTE_W-1:0]  data;
        logic [nrzifr_pkg::STAGE_W-1:0] stage;
    } frame_t;

    // bit recovery, flag hunt and stage tracking, one call per accepted request
    class frame_scoreboard;
        logic [nrzifr_pkg::SPB_W-1:0]     period;
        logic                             prev_level;
        logic                             first_seen;
        logic [nrzifr_pkg::SPB_W-1:0]     bit_phase;
        logic                             half_skip_done;
        logic [nrzifr_pkg::BYTE_W-1:0]    window;
        logic [nrzifr_pkg::BIT_CNT_W-1:0] bits_in_byte;
        logic [nrzifr_pkg::STAGE_W-1:0]   stage;
        frame_t                           pending_frames[$];
        int                               errors;
        int                               results_seen;

        function new();
            period = nrzifr_pkg::SPB_RESET;
            prev_level = 1'b0;
            first_seen = 1'b0;
            bit_phase = '0;
            half_skip_done = 1'b0;
            window = '0;
            bits_in_byte = '0;
            stage = nrzifr_pkg::STAGE_HUNT;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_period(logic [nrzifr_pkg::SPB_W-1:0] value);
            period = value;
        endfunction

        function void shift_in_bit(logic bit_val);
            frame_t produced;
            window = {bit_val, window[nrzifr_pkg::BYTE_W-1:1]};
            if (stage == nrzifr_pkg::STAGE_HUNT)
            begin
                if (window == nrzifr_pkg::FLAG_BYTE)
                begin
                    stage = nrzifr_pkg::STAGE_FLAG;
                    produced.data = nrzifr_pkg::FLAG_BYTE;
                    produced.stage = nrzifr_pkg::STAGE_FLAG;
                    pending_frames.push_back(produced);
                    window = '0;
                    bits_in_byte = '0;
                end
            end
            else
            begin
                bits_in_byte = bits_in_byte + 1'b1;
                if (bits_in_byte == '0)
                begin
                    case (stage)
                        nrzifr_pkg::STAGE_FLAG:
                            if (window != nrzifr_pkg::FLAG_BYTE)
                                stage = nrzifr_pkg::STAGE_ADDR;
                        nrzifr_pkg::STAGE_ADDR:
                            if (window == nrzifr_pkg::CONTROL_BYTE)
                                stage = nrzifr_pkg::STAGE_CTRL;
                        nrzifr_pkg::STAGE_CTRL:
                            if (window == nrzifr_pkg::PID_BYTE)
                                stage = nrzifr_pkg::STAGE_PID;
                        default: ;
                    endcase
                    produced.data = window;
                    produced.stage = stage;
                    pending_frames.push_back(produced);
                    window = '0;
                end
            end
        endfunction

        function void note_sample(logic level);
            logic                       have_bit;
            logic                       bit_val;
            logic [nrzifr_pkg::SPB_W:0] next_phase;
            have_bit = 1'b0;
            bit_val = 1'b0;
            if (!first_seen)
            begin
                first_seen = 1'b1;
                prev_level = level;
            end
            else if (level != prev_level)
            begin
                // edge: a zero bit, phase to mid bit
                prev_level = level;
                bit_phase = period >> 1;
                half_skip_done = 1'b0;
                have_bit = 1'b1;
            end
            next_phase = {1'b0, bit_phase} + 1'b1;
            if (period != '0 && next_phase >= {1'b0, period})
            begin
                bit_phase = '0;
                if (!half_skip_done)
                    half_skip_done = 1'b1;
                else
                begin
                    have_bit = 1'b1;
                    bit_val = 1'b1;
                end
            end
            else
                bit_phase = next_phase[nrzifr_pkg::SPB_W-1:0];
            if (have_bit)
                shift_in_bit(bit_val);
        endfunction

        function void check_frame(logic [nrzifr_pkg::BYTE_W-1:0] got_byte,
                                  logic [nrzifr_pkg::STAGE_W-1:0] got_stage);
            frame_t want;
            results_seen++;
            if (pending_frames.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected frame request, expected none, %s %02h stage %0d",
                             $time, "got byte", got_byte, got_stage);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (want.data !== got_byte || want.stage !== got_stage)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: frame mismatch, expected byte %02h stage %0d, %s %02h %s %0d",
                                 $time, want.data, want.stage, "got byte", got_byte,
                                 "stage", got_stage);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [nrzifr_pkg::SPB_W-1:0] cfg_wr_data;

    nrzifr_sample_if sample_ch();
    nrzifr_frame_if  frame_ch();

    nrzi_bit_recovery_flag_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample_ch),
        .frame       (frame_ch)
    );

    frame_scoreboard sb = new();

    int   tx_mode = 1;
    int   rx_mode = 1;
    bit   hold_request = 0;
    bit   rough = 0;
    int   cur_period = nrzifr_pkg::SPB_RESET;
    int   sent_items = 0;
    int   periods_run = 0;
    logic tx_level = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

    function automatic int pick_gap(int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // frame side: random ready, one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        frame_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
                sb.check_frame(frame_ch.frame_byte, frame_ch.frame_stage);
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                frame_ch.ready <= 1'b0;
            end
            else
            begin
                frame_ch.ready <= 1'b1;
                stall_left = pick_gap(rx_mode);
            end
        end
    end

    task automatic send_sample(input logic level);
        int gap;
        sample_ch.valid <= 1'b1;
        sample_ch.line_sample <= level;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        sb.note_sample(level);
        sent_items++;
        gap = pick_gap(tx_mode);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // nrzi: zero toggles the line, one holds it
    task automatic send_bit(input logic bit_val);
        int len;
        int k;
        if (bit_val == 1'b0)
            tx_level = ~tx_level;
        if (cur_period == 0)
            len = $urandom_range(1, 4);
        else
        begin
            len = cur_period;
            if (rough && cur_period >= 3 && $urandom_range(9) == 0)
                len = $urandom_range(1) ? len + 1 : len - 1;
        end
        for (k = 0; k < len; k++)
        begin
            if (rough && $urandom_range(49) == 0)
                send_sample(~tx_level);
            else
                send_sample(tx_level);
        end
    endtask

    task automatic send_byte(input logic [nrzifr_pkg::BYTE_W-1:0] value);
        int i;
        for (i = 0; i < nrzifr_pkg::BYTE_W; i++)
            send_bit(value[i]);
    endtask

    task automatic send_random_bits(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_bit(1'($urandom_range(1)));
    endtask

    task automatic send_frame(input int payload_len);
        int i;
        send_byte(nrzifr_pkg::FLAG_BYTE);
        send_byte(nrzifr_pkg::FLAG_BYTE);
        send_byte(8'($urandom));
        // broken frame now and then: control byte missing
        if (!rough || $urandom_range(4) != 0)
            send_byte(nrzifr_pkg::CONTROL_BYTE);
        send_byte(nrzifr_pkg::PID_BYTE);
        for (i = 0; i < payload_len; i++)
            send_byte(8'($urandom));
        send_byte(nrzifr_pkg::FLAG_BYTE);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(input int value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= nrzifr_pkg::SPB_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_period(nrzifr_pkg::SPB_W'(value));
        cur_period = value;
        periods_run++;
    endtask

    task automatic run_phase(input int period, input int payload_len);
        wait_idle();
        write_period(period);
        tx_mode = $urandom_range(3) != 0;
        rx_mode = $urandom_range(3) != 0;
        rough = $urandom_range(2) == 0;
        if (period > 30)
            send_random_bits($urandom_range(2, 3));
        else
        begin
            if (rough && $urandom_range(3) == 0)
                send_random_bits($urandom_range(1, 7));
            send_frame(payload_len);
        end
    endtask

    initial
    begin
        int i;
        int r;
        int period;
        rst_n = 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.line_sample <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short level pattern at the reset bit period, first sample high
        for (i = 0; i < 24; i++)
            send_sample(DIRECTED_LEVELS[i]);
        tx_level = DIRECTED_LEVELS[23];

        // longest period, then lowered below the running phase
        run_phase(63, 0);

        wait_idle();
        write_period(3);
        tx_mode = 0;
        rx_mode = 1;
        rough = 0;
        hold_request = 1;
        send_frame(2);

        run_phase(0, 1);
        run_phase(1, 1);
        run_phase(2, 1);

        while (sent_items < 1000)
        begin
            r = $urandom_range(99);
            if (r < 80)
                period = $urandom_range(3, 12);
            else if (r < 95)
                period = $urandom_range(13, 30);
            else
                period = $urandom_range(31, 63);
            run_phase(period, $urandom_range(1, 4));
        end

        wait_idle();
        $display("run covered %0d line samples and %0d frame bytes over %0d bit period settings",
                 sent_items, sb.results_seen, periods_run);
        $display("periods 0, 1, 2, 3 and 63 included, with a long output hold-off");
        if (sb.errors == 0 && sb.pending_frames.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
